// File: hw/rtl/ecol_pkg.sv
package ecol_pkg;

	// depth of the word queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// File: hw/rtl/elastic_collision_2d_equal_mass_core.sv
// Division: the long division in the back half resolves one quotient bit a stage.
// Throughput: one word per cycle while the output is not stalled; the four-word queue
// and the output register decouple the input from a stalled output.
// Reset: arst_n clears every valid and queue pointer at once; data registers keep
// whatever they hold and are ignored until refilled.
module elastic_collision_2d_equal_mass_core
	import ecol_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [WORD_BITS-1:0] pos_a_x,
	input  logic signed [WORD_BITS-1:0] pos_a_y,
	input  logic signed [WORD_BITS-1:0] vel_a_x,
	input  logic signed [WORD_BITS-1:0] vel_a_y,
	input  logic signed [WORD_BITS-1:0] pos_b_x,
	input  logic signed [WORD_BITS-1:0] pos_b_y,
	input  logic signed [WORD_BITS-1:0] vel_b_x,
	input  logic signed [WORD_BITS-1:0] vel_b_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [WORD_BITS-1:0] new_vel_a_x,
	output logic signed [WORD_BITS-1:0] new_vel_a_y,
	output logic signed [WORD_BITS-1:0] new_vel_b_x,
	output logic signed [WORD_BITS-1:0] new_vel_b_y,
	output logic                        centres_coincide,
	output logic                        saturated
);

	localparam int RW = 8 * WORD_BITS + 5;

	logic          push;
	logic          pop;
	logic          back_en;
	logic [RW-1:0] front_rec;
	logic [RW-1:0] head_rec;
	fifo_stat_t    fstat;

	// Front: form differences, flag coinciding centres, hold one word.
	ecol_front #(.W(WORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pos_a_x  (pos_a_x),
		.pos_a_y  (pos_a_y),
		.vel_a_x  (vel_a_x),
		.vel_a_y  (vel_a_y),
		.pos_b_x  (pos_b_x),
		.pos_b_y  (pos_b_y),
		.vel_b_x  (vel_b_x),
		.vel_b_y  (vel_b_y),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (fstat),
		.push     (push),
		.rec      (front_rec)
	);

	// Queue between the two halves, so each side stalls on its own.
	ecol_fifo #(.WIDTH(RW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_rec),
		.pop    (pop),
		.dout   (head_rec),
		.stat   (fstat)
	);

	// Back: advance the whole pipeline unless a finished word waits at the output.
	assign back_en = !out_valid || !out_stall;
	assign pop     = back_en && !fstat.empty;

	ecol_back #(.W(WORD_BITS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (back_en),
		.take             (pop),
		.rec              (head_rec),
		.out_valid        (out_valid),
		.new_vel_a_x      (new_vel_a_x),
		.new_vel_a_y      (new_vel_a_y),
		.new_vel_b_x      (new_vel_b_x),
		.new_vel_b_y      (new_vel_b_y),
		.centres_coincide (centres_coincide),
		.saturated        (saturated)
	);

	// coinciding centres pass velocities unchanged, so nothing can clip
	a_coin_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && centres_coincide) |-> !saturated)
		else $error("saturation flagged on coinciding centres");

	// input held back only when the queue is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> fstat.full)
		else $error("input stalled with room in the queue");

	// a pop never leaves the queue empty-and-popped
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fstat.empty)
		else $error("pop from empty queue");

endmodule

// File: hw/rtl/ecol_fifo.sv
module ecol_fifo
	import ecol_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output fifo_stat_t       stat
);

	logic [WIDTH-1:0]   mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign dout       = mem_q[rd_q];
	assign stat.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

// File: hw/rtl/ecol_front.sv
module ecol_front
	import ecol_pkg::*;
#(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [W-1:0] pos_a_x,
	input  logic signed [W-1:0] pos_a_y,
	input  logic signed [W-1:0] vel_a_x,
	input  logic signed [W-1:0] vel_a_y,
	input  logic signed [W-1:0] pos_b_x,
	input  logic signed [W-1:0] pos_b_y,
	input  logic signed [W-1:0] vel_b_x,
	input  logic signed [W-1:0] vel_b_y,
	input  logic                in_valid,
	output logic                in_stall,
	input  fifo_stat_t          stat,
	output logic                push,
	output logic [8*W+4:0]      rec
);

	logic [W:0]     dx, dy, dvx, dvy;
	logic           coin;
	logic           f_valid_q;
	logic [8*W+4:0] rec_q;
	logic           accept;

	// differences one bit wider than the fields, so they never wrap
	assign dx   = {pos_a_x[W-1], pos_a_x} - {pos_b_x[W-1], pos_b_x};
	assign dy   = {pos_a_y[W-1], pos_a_y} - {pos_b_y[W-1], pos_b_y};
	assign dvx  = {vel_a_x[W-1], vel_a_x} - {vel_b_x[W-1], vel_b_x};
	assign dvy  = {vel_a_y[W-1], vel_a_y} - {vel_b_y[W-1], vel_b_y};
	assign coin = (dx == '0) && (dy == '0);

	assign in_stall = f_valid_q && stat.full;
	assign accept   = in_valid && !in_stall;
	assign push     = f_valid_q && !stat.full;
	assign rec      = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_q <= 1'b0;
		end else if (accept) begin
			f_valid_q <= 1'b1;
		end else if (push) begin
			f_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_q <= {coin, dx, dy, dvx, dvy, vel_a_x, vel_a_y, vel_b_x, vel_b_y};
		end
	end

endmodule

// File: hw/rtl/ecol_div.sv
module ecol_div #(
	parameter int W = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [3*W+1:0]   p,
	input  logic [2*W+1:0]   den,
	output logic [W+1:0]     q
);

	localparam int QB = W + 2;
	localparam int DW = 2 * W + 2;
	localparam int PW = 3 * W + 2;

	logic [DW-1:0] rem_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic [QB-1:0] low_s [QB];
	logic [QB-1:0] q_q;
	logic          up;

	// the quotient is below 2^QB, so the bits above QB start the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(p[PW-1:QB]);
			low_s[0] <= p[QB-1:0];
			den_s[0] <= den;
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DW:0] t;
		logic [DW:0] d;
		logic        ge;

		assign t  = {rem_s[k], low_s[k][QB-1-k]};
		assign d  = t - {1'b0, den_s[k]};
		assign ge = (t >= {1'b0, den_s[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? d[DW-1:0] : t[DW-1:0];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
			end
		end

		if (k < QB - 1) begin : g_low
			always_ff @(posedge clk) begin
				if (en) begin
					low_s[k+1] <= low_s[k];
				end
			end
		end
	end

	// round half away from zero: bump when twice the remainder reaches den
	assign up = ({rem_s[QB], 1'b0} >= {1'b0, den_s[QB]});

	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= quo_s[QB] + QB'(up);
		end
	end

	assign q = q_q;

endmodule

// File: hw/rtl/ecol_back.sv
module ecol_back
	import ecol_pkg::*;
#(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                take,
	input  logic [8*W+4:0]      rec,
	output logic                out_valid,
	output logic signed [W-1:0] new_vel_a_x,
	output logic signed [W-1:0] new_vel_a_y,
	output logic signed [W-1:0] new_vel_b_x,
	output logic signed [W-1:0] new_vel_b_y,
	output logic                centres_coincide,
	output logic                saturated
);

	localparam int QB  = W + 2;
	localparam int PW  = 3 * W + 2;
	localparam int SW  = W + 4;
	localparam int DL  = QB + 2;
	localparam int SDW = 4 * W + 3;
	localparam int MW  = 2 * W + 2;

	function automatic logic [W:0] sat_fn(input logic [SW-1:0] s);
		logic hi, lo;
		hi = !s[SW-1] && (|s[SW-2:W-1]);
		lo = s[SW-1] && !(&s[SW-2:W-1]);
		if (hi) begin
			sat_fn = {1'b1, 1'b0, {(W-1){1'b1}}};
		end else if (lo) begin
			sat_fn = {1'b1, 1'b1, {(W-1){1'b0}}};
		end else begin
			sat_fn = {1'b0, s[W-1:0]};
		end
	endfunction

	logic           r_coin;
	logic [W:0]     r_dx, r_dy, r_dvx, r_dvy;
	logic [4*W-1:0] r_vel;

	assign {r_coin, r_dx, r_dy, r_dvx, r_dvy, r_vel} = rec;

	logic           v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, out_valid_q;
	logic [W:0]     adx_s1, ady_s1, advx_s1, advy_s1;
	logic           negx_s1, negy_s1, sdx_s1, sdy_s1, coin_s1;
	logic [4*W-1:0] vel_s1;

	logic [2*W+1:0] tx_s2, ty_s2, sqx_s2, sqy_s2;
	logic [W:0]     adx_s2, ady_s2;
	logic           negx_s2, negy_s2, sdx_s2, sdy_s2, coin_s2;
	logic [4*W-1:0] vel_s2;

	logic [2*W+2:0] num_s3;
	logic [2*W+1:0] den_s3;
	logic [W:0]     adx_s3, ady_s3;
	logic           sdx_s3, sdy_s3, coin_s3;
	logic [4*W-1:0] vel_s3;

	logic [2*W+1:0] num_s4, den_s4;
	logic [W:0]     adx_s4, ady_s4;
	logic           dnx_s4, dny_s4, coin_s4;
	logic [4*W-1:0] vel_s4;

	logic [2*W+1:0] plx_s5, phx_s5, ply_s5, phy_s5, den_s5;
	logic           dnx_s5, dny_s5, coin_s5;
	logic [4*W-1:0] vel_s5;

	logic [PW-1:0]  px_s6, py_s6;
	logic [2*W+1:0] den_s6;
	logic [SDW-1:0] sd6;
	logic           dnx_s6, dny_s6, coin_s6;
	logic [4*W-1:0] vel_s6;

	logic [SDW-1:0] sd_s [DL];
	logic           vd_s [DL];
	logic [QB-1:0]  qx, qy;

	logic [SW-1:0]  ax_s7, ay_s7, bx_s7, by_s7;
	logic           coin_s7;
	logic [4*W-1:0] vel_s7;

	logic [W:0]     sax, say, sbx, sby;
	logic [W-1:0]   ovax_q, ovay_q, ovbx_q, ovby_q;
	logic           ocoin_q, osat_q;

	logic [2*W+2:0] ex_x, ex_y, term_x, term_y;
	logic           nneg;
	logic [2*W+2:0] nmag;

	logic           d_coin, d_dnx, d_dny;
	logic [4*W-1:0] d_vel;
	logic [SW-1:0]  vax_e, vay_e, vbx_e, vby_e, qx_e, qy_e;

	assign ex_x   = {1'b0, tx_s2};
	assign ex_y   = {1'b0, ty_s2};
	assign term_x = negx_s2 ? (~ex_x + 1'b1) : ex_x;
	assign term_y = negy_s2 ? (~ex_y + 1'b1) : ex_y;
	assign nneg   = num_s3[2*W+2];
	assign nmag   = nneg ? (~num_s3 + 1'b1) : num_s3;
	assign sd6    = {coin_s6, dnx_s6, dny_s6, vel_s6};

	// valid chain, frozen together with the data when the output is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DL; i++) begin
				vd_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= take;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			vd_s[0] <= v_s6;
			for (int i = 1; i < DL; i++) begin
				vd_s[i] <= vd_s[i-1];
			end
			v_s7        <= vd_s[DL-1];
			out_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// magnitudes and product signs
			adx_s1  <= r_dx[W] ? (~r_dx + 1'b1) : r_dx;
			ady_s1  <= r_dy[W] ? (~r_dy + 1'b1) : r_dy;
			advx_s1 <= r_dvx[W] ? (~r_dvx + 1'b1) : r_dvx;
			advy_s1 <= r_dvy[W] ? (~r_dvy + 1'b1) : r_dvy;
			negx_s1 <= r_dx[W] ^ r_dvx[W];
			negy_s1 <= r_dy[W] ^ r_dvy[W];
			sdx_s1  <= r_dx[W];
			sdy_s1  <= r_dy[W];
			coin_s1 <= r_coin;
			vel_s1  <= r_vel;

			// products
			tx_s2   <= MW'(advx_s1) * MW'(adx_s1);
			ty_s2   <= MW'(advy_s1) * MW'(ady_s1);
			sqx_s2  <= MW'(adx_s1) * MW'(adx_s1);
			sqy_s2  <= MW'(ady_s1) * MW'(ady_s1);
			adx_s2  <= adx_s1;
			ady_s2  <= ady_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			sdx_s2  <= sdx_s1;
			sdy_s2  <= sdy_s1;
			coin_s2 <= coin_s1;
			vel_s2  <= vel_s1;

			// signed dot product and squared distance
			num_s3  <= term_x + term_y;
			den_s3  <= sqx_s2 + sqy_s2;
			adx_s3  <= adx_s2;
			ady_s3  <= ady_s2;
			sdx_s3  <= sdx_s2;
			sdy_s3  <= sdy_s2;
			coin_s3 <= coin_s2;
			vel_s3  <= vel_s2;

			num_s4  <= nmag[2*W+1:0];
			den_s4  <= den_s3;
			dnx_s4  <= nneg ^ sdx_s3;
			dny_s4  <= nneg ^ sdy_s3;
			adx_s4  <= adx_s3;
			ady_s4  <= ady_s3;
			coin_s4 <= coin_s3;
			vel_s4  <= vel_s3;

			// split the wide product into two halves
			plx_s5  <= MW'(adx_s4) * MW'(num_s4[W:0]);
			phx_s5  <= MW'(adx_s4) * MW'(num_s4[2*W+1:W+1]);
			ply_s5  <= MW'(ady_s4) * MW'(num_s4[W:0]);
			phy_s5  <= MW'(ady_s4) * MW'(num_s4[2*W+1:W+1]);
			den_s5  <= den_s4;
			dnx_s5  <= dnx_s4;
			dny_s5  <= dny_s4;
			coin_s5 <= coin_s4;
			vel_s5  <= vel_s4;

			px_s6   <= PW'(plx_s5) + (PW'(phx_s5) << (W + 1));
			py_s6   <= PW'(ply_s5) + (PW'(phy_s5) << (W + 1));
			den_s6  <= den_s5;
			dnx_s6  <= dnx_s5;
			dny_s6  <= dny_s5;
			coin_s6 <= coin_s5;
			vel_s6  <= vel_s5;

			sd_s[0] <= sd6;
			for (int i = 1; i < DL; i++) begin
				sd_s[i] <= sd_s[i-1];
			end
		end
	end

	ecol_div #(.W(W)) u_div_x (
		.clk (clk),
		.en  (en),
		.p   (px_s6),
		.den (den_s6),
		.q   (qx)
	);

	ecol_div #(.W(W)) u_div_y (
		.clk (clk),
		.en  (en),
		.p   (py_s6),
		.den (den_s6),
		.q   (qy)
	);

	assign {d_coin, d_dnx, d_dny, d_vel} = sd_s[DL-1];

	assign vax_e = {{4{d_vel[4*W-1]}}, d_vel[4*W-1 -: W]};
	assign vay_e = {{4{d_vel[3*W-1]}}, d_vel[3*W-1 -: W]};
	assign vbx_e = {{4{d_vel[2*W-1]}}, d_vel[2*W-1 -: W]};
	assign vby_e = {{4{d_vel[W-1]}}, d_vel[W-1:0]};
	assign qx_e  = {2'b00, qx};
	assign qy_e  = {2'b00, qy};

	assign sax = sat_fn(ax_s7);
	assign say = sat_fn(ay_s7);
	assign sbx = sat_fn(bx_s7);
	assign sby = sat_fn(by_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			// a negative delta swaps the subtract and the add on each side
			ax_s7   <= d_dnx ? (vax_e + qx_e) : (vax_e - qx_e);
			ay_s7   <= d_dny ? (vay_e + qy_e) : (vay_e - qy_e);
			bx_s7   <= d_dnx ? (vbx_e - qx_e) : (vbx_e + qx_e);
			by_s7   <= d_dny ? (vby_e - qy_e) : (vby_e + qy_e);
			coin_s7 <= d_coin;
			vel_s7  <= d_vel;

			ocoin_q <= coin_s7;
			if (coin_s7) begin
				ovax_q <= vel_s7[4*W-1 -: W];
				ovay_q <= vel_s7[3*W-1 -: W];
				ovbx_q <= vel_s7[2*W-1 -: W];
				ovby_q <= vel_s7[W-1:0];
				osat_q <= 1'b0;
			end else begin
				ovax_q <= sax[W-1:0];
				ovay_q <= say[W-1:0];
				ovbx_q <= sbx[W-1:0];
				ovby_q <= sby[W-1:0];
				osat_q <= sax[W] | say[W] | sbx[W] | sby[W];
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign new_vel_a_x      = ovax_q;
	assign new_vel_a_y      = ovay_q;
	assign new_vel_b_x      = ovbx_q;
	assign new_vel_b_y      = ovby_q;
	assign centres_coincide = ocoin_q;
	assign saturated        = osat_q;

endmodule

// File: sim/elastic_collision_2d_equal_mass_core_tb.sv
module elastic_collision_2d_equal_mass_core_tb;

	typedef struct packed {
		logic signed [31:0] pax, pay, vax, vay, pbx, pby, vbx, vby;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] vax, vay, vbx, vby;
		logic               coincide;
		logic               sat;
	} rebound_t;

	localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;
	localparam int N_RANDOM = 700;
	localparam int LIMIT = 400000;

	// expected rebounds, oldest first; prediction done in plain wide integers
	class collision_board;
		rebound_t rebounds[$];
		int       errors;

		function logic [127:0] mag(longint v);
			return v < 0 ? 128'(-v) : 128'(v);
		endfunction

		// round half away from zero, clamp to 2^62, then apply sign
		function longint axis_delta(longint d, logic [127:0] num, bit nneg,
				logic [127:0] den);
			logic [127:0] q;
			q = ((mag(d) * num) * 2 + den) / (den * 2);
			if (q >= (128'd1 << 62))
				q = 128'd1 << 62;
			return (nneg != (d < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function logic signed [31:0] clip(longint v, inout bit flag);
			if (v > longint'(MAXV)) begin
				flag = 1;
				return MAXV;
			end
			if (v < longint'(MINV)) begin
				flag = 1;
				return MINV;
			end
			return v[31:0];
		endfunction

		function void note_pair(pair_t p);
			longint dx, dy, dvx, dvy, dlx, dly;
			logic [127:0] den, t1, t2, pos, neg, num;
			bit nneg, flag;
			rebound_t r;
			dx = longint'(p.pax) - longint'(p.pbx);
			dy = longint'(p.pay) - longint'(p.pby);
			dvx = longint'(p.vax) - longint'(p.vbx);
			dvy = longint'(p.vay) - longint'(p.vby);
			flag = 0;
			if (dx == 0 && dy == 0) begin
				r = '{p.vax, p.vay, p.vbx, p.vby, 1'b1, 1'b0};
			end else begin
				den = mag(dx) * mag(dx) + mag(dy) * mag(dy);
				t1 = mag(dvx) * mag(dx);
				t2 = mag(dvy) * mag(dy);
				pos = 0;
				neg = 0;
				if ((dvx < 0) != (dx < 0)) neg += t1; else pos += t1;
				if ((dvy < 0) != (dy < 0)) neg += t2; else pos += t2;
				nneg = pos < neg;
				num = nneg ? neg - pos : pos - neg;
				dlx = axis_delta(dx, num, nneg, den);
				dly = axis_delta(dy, num, nneg, den);
				r.vax = clip(longint'(p.vax) - dlx, flag);
				r.vay = clip(longint'(p.vay) - dly, flag);
				r.vbx = clip(longint'(p.vbx) + dlx, flag);
				r.vby = clip(longint'(p.vby) + dly, flag);
				r.coincide = 0;
				r.sat = flag;
			end
			rebounds.push_back(r);
		endfunction

		function void check_rebound(rebound_t a);
			rebound_t e;
			if (rebounds.size() == 0) begin
				$error("unexpected result word");
				errors++;
				return;
			end
			e = rebounds.pop_front();
			if (a.vax !== e.vax) begin
				$error("new_vel_a_x exp %0d got %0d", e.vax, a.vax); errors++;
			end
			if (a.vay !== e.vay) begin
				$error("new_vel_a_y exp %0d got %0d", e.vay, a.vay); errors++;
			end
			if (a.vbx !== e.vbx) begin
				$error("new_vel_b_x exp %0d got %0d", e.vbx, a.vbx); errors++;
			end
			if (a.vby !== e.vby) begin
				$error("new_vel_b_y exp %0d got %0d", e.vby, a.vby); errors++;
			end
			if (a.coincide !== e.coincide) begin
				$error("centres_coincide exp %0b got %0b", e.coincide, a.coincide); errors++;
			end
			if (a.sat !== e.sat) begin
				$error("saturated exp %0b got %0b", e.sat, a.sat); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	pair_t drv = '0;
	logic signed [31:0] new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y;
	logic centres_coincide, saturated;

	collision_board board = new();
	bit burst = 0;      // no idling on either side while set
	bit hold_out = 0;   // ask the receiver for a long hold-off
	int cycles = 0;

	elastic_collision_2d_equal_mass_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_a_x(drv.pax), .pos_a_y(drv.pay), .vel_a_x(drv.vax), .vel_a_y(drv.vay),
		.pos_b_x(drv.pbx), .pos_b_y(drv.pby), .vel_b_x(drv.vbx), .vel_b_y(drv.vby),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_vel_a_x(new_vel_a_x), .new_vel_a_y(new_vel_a_y),
		.new_vel_b_x(new_vel_b_x), .new_vel_b_y(new_vel_b_y),
		.centres_coincide(centres_coincide), .saturated(saturated)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("elastic_collision_2d_equal_mass_core_tb: errors");
			$finish;
		end
	end

	// check every result word taken at an edge (pre-edge values seen here)
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_rebound('{new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
				centres_coincide, saturated});
	end

	// receiver: random stall per word, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_out) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				hold_out = 0;
			end else begin
				n = burst ? 0 : $urandom_range(11);
				if (n > 0) begin
					out_stall <= 1;
					repeat (n) @(posedge clk);
				end
			end
			out_stall <= 0;
			@(posedge clk);
		end
	end

	// offer one word and hold it until taken
	task automatic send_pair(pair_t p);
		int gap;
		drv <= p;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		board.note_pair(p);
		gap = burst ? 0 : $urandom_range(11);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick(int kind);
		case (kind)
			0: return $urandom;
			1: return $signed($urandom_range(32'h3_0000)) - 32'sh1_8000;
			2: return $urandom_range(1) ? MAXV - $urandom_range(3) : MINV + $urandom_range(3);
			default: return $signed($urandom_range(32'h100)) - 32'sh80;
		endcase
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int kind;
		kind = $urandom_range(3);
		p = '{pick(kind), pick(kind), pick($urandom_range(3)), pick($urandom_range(3)),
			pick(kind), pick(kind), pick($urandom_range(3)), pick($urandom_range(3))};
		case ($urandom_range(9))
			// coinciding centres
			0: begin
				p.pbx = p.pax;
				p.pby = p.pay;
			end
			// velocities perpendicular to the axis: zero projection
			1: begin
				p.pbx = p.pax - 32'sd3;
				p.pby = p.pay;
				p.vbx = p.vax;
			end
			// one axis aligned
			2: p.pby = p.pay;
			default: ;
		endcase
		return p;
	endfunction

	initial begin
		pair_t p;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zeros, coincidence, zero projection, extremes, saturation
		send_pair('0);
		send_pair('{0, 0, MAXV, MINV, 0, 0, MINV, MAXV});
		send_pair('{MAXV, MAXV, 32'sh1_0000, 0, MAXV, MAXV, 0, 0});
		send_pair('{32'sh2_0000, 0, 0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000});
		send_pair('{32'sh1_0000, 0, 32'sh1_0000, 0, 0, 0, -32'sh1_0000, 0});
		send_pair('{MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV});
		send_pair('{MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV});
		send_pair('{MAXV, 0, MAXV, 0, MINV, 0, MINV, 0});
		send_pair('{0, MINV, 0, MAXV, 0, MAXV, 0, MINV});
		send_pair('{32'sh1, 0, MAXV, 0, 0, 0, 0, 0});
		send_pair('{32'sh1, 32'sh1, 32'sh1, 0, 0, 0, 0, 0});
		send_pair('{32'sh1, 32'sh1, -32'sh1, 0, 0, 0, 0, 0});
		send_pair('{32'sh3, 32'sh4, 32'sh7, -32'sh2, 0, 0, 0, 0});
		send_pair('{-32'sh1, -32'sh1, MINV, MINV, 0, 0, MAXV, MAXV});
		send_pair('{32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
			32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa});

		for (int i = 0; i < N_RANDOM; i++) begin
			// alternate idling and flat-out stretches
			if (i % 60 == 0)
				burst = $urandom_range(2) == 0;
			// long receiver hold-off while words keep coming
			if (i == 200) begin
				burst = 1;
				hold_out = 1;
			end
			// pause until everything in flight has come back
			if (i == 400) begin
				in_valid <= 0;
				while (board.rebounds.size() != 0) @(posedge clk);
			end
			send_pair(random_pair());
		end
		in_valid <= 0;
		while (board.rebounds.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		if (board.errors == 0)
			$display("elastic_collision_2d_equal_mass_core_tb: clean");
		else
			$display("elastic_collision_2d_equal_mass_core_tb: errors");
		$finish;
	end

endmodule
